@@ hw/rtl/sapc_pkg.sv @@
// ----------------------------------------------------------------------------
// sapc_pkg
// Shared types and constants for the source address packet counter.
// ----------------------------------------------------------------------------
package sapc_pkg;

  localparam int unsigned ADDR_W = 32;   // IPv4 source address
  localparam int unsigned COUNT_W = 32;  // per-address packet count
  localparam int unsigned USED_W = 9;    // reported fill level

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  // One table row: address and its count, kept side by side in one RAM word.
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } sapc_entry_t;

  localparam int unsigned ENTRY_W = $bits(sapc_entry_t);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } sapc_state_t;

endpackage

@@ hw/rtl/sapc_ram.sv @@
// ----------------------------------------------------------------------------
// sapc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sapc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/source_address_packet_counter.sv @@
// ----------------------------------------------------------------------------
// source_address_packet_counter
// Per-source-address packet counter with a linear-search table in RAM.
// ----------------------------------------------------------------------------
// Each start transaction carries one IPv4 source address. The block walks the
// entries in use of a table RAM (address and count in one word), one read per
// cycle, comparing each returned word against the address in the cycle after
// the read. On a match the count is raised by one (saturating at all ones)
// and written back; on a miss the address is appended with count one, or,
// when the table already holds TABLE_DEPTH entries, dropped and flagged as
// table_full. The single RAM read port, walked one entry per cycle, bounds
// the search time: a hit costs more the later its entry lies, and a miss on
// a full table is the slowest case.
// busy is high from acceptance until the result is shown; the result appears
// on the out_ ports for exactly one cycle with out_valid high, and the next
// start may be taken in that same cycle. The receiver cannot stall. No
// clearing pass follows reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module source_address_packet_counter
  import sapc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [ADDR_W-1:0]  in_source_address,
  // result channel
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_packet_count,
  output logic               out_is_new,
  output logic               out_table_full,
  output logic [USED_W-1:0]  out_entries_used
);

  // RAM index width and the width of the fill counter (holds TABLE_DEPTH).
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > USED_W) ? CNT_W : USED_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  sapc_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] key_r, key_nxt;          // address under search
  logic [CNT_W-1:0]  entry_cnt_r, entry_cnt_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;    // next entry to read
  logic              cmp_vld_r, cmp_vld_nxt;  // RAM data is valid this cycle
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;  // entry whose data is returning

  // registered result
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_new_r, out_new_nxt;
  logic               out_full_r, out_full_nxt;
  logic [CNT_W-1:0]   out_used_r, out_used_nxt;
  logic [EXT_W-1:0]   out_used_ext;

  // RAM port signals
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  sapc_entry_t       ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  sapc_entry_t       rd_entry;

  logic              issue_vld;
  logic              hit;
  logic [COUNT_W-1:0] inc_count;

  sapc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry  = sapc_entry_t'(ram_rdata);
  assign ram_raddr = rd_idx_r[IDX_W-1:0];

  // Entries below the fill count are the only ones ever read.
  assign issue_vld = (state_r == ST_SCAN) && (rd_idx_r < entry_cnt_r);
  assign hit       = cmp_vld_r && (rd_entry.addr == key_r);
  assign inc_count = (rd_entry.count == COUNT_MAX) ? COUNT_MAX
                                                   : rd_entry.count + COUNT_ONE;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    entry_cnt_nxt = entry_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    out_used_nxt  = out_used_r;
    ram_we        = 1'b0;
    ram_waddr     = cmp_idx_r;
    ram_wdata     = '{addr: key_r, count: inc_count};
    ram_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt    = in_source_address;
          rd_idx_nxt = '0;
          state_nxt  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Read one entry per cycle; compare its data in the cycle after the read.
        ram_re      = issue_vld;
        cmp_vld_nxt = issue_vld;
        cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
        if (issue_vld) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end

        if (hit) begin
          // known address: saturating increment, written back in place
          ram_we        = 1'b1;
          ram_waddr     = cmp_idx_r;
          ram_wdata     = '{addr: key_r, count: inc_count};
          out_valid_nxt = 1'b1;
          out_count_nxt = inc_count;
          out_new_nxt   = 1'b0;
          out_full_nxt  = 1'b0;
          out_used_nxt  = entry_cnt_r;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (!issue_vld && !cmp_vld_r) begin
          // search exhausted without a match
          out_valid_nxt = 1'b1;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
          if (entry_cnt_r != DEPTH_CNT) begin
            ram_we        = 1'b1;
            ram_waddr     = entry_cnt_r[IDX_W-1:0];
            ram_wdata     = '{addr: key_r, count: COUNT_ONE};
            entry_cnt_nxt = entry_cnt_r + CNT_W'(1);
            out_count_nxt = COUNT_ONE;
            out_new_nxt   = 1'b1;
            out_full_nxt  = 1'b0;
            out_used_nxt  = entry_cnt_r + CNT_W'(1);
          end else begin
            out_count_nxt = '0;
            out_new_nxt   = 1'b0;
            out_full_nxt  = 1'b1;
            out_used_nxt  = entry_cnt_r;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      entry_cnt_r <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan pointers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    out_count_r <= out_count_nxt;
    out_new_r   <= out_new_nxt;
    out_full_r  <= out_full_nxt;
    out_used_r  <= out_used_nxt;
  end

  // Fill level reported as its low USED_W bits.
  assign out_used_ext = EXT_W'(out_used_r);

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_packet_count = out_count_r;
  assign out_is_new       = out_new_r;
  assign out_table_full   = out_full_r;
  assign out_entries_used = out_used_ext[USED_W-1:0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An accepted transaction leaves the block searching next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start a search");

  // The result strobe coincides with the return to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result shown outside end of search");

  // A newly inserted address starts at one and never comes with the drop flag.
  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_new) |-> (!out_table_full && out_packet_count == COUNT_ONE))
    else $error("inconsistent new-entry result");

  // The fill count never runs past the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt_r <= DEPTH_CNT)
    else $error("fill count beyond table depth");

endmodule
